@@ rtl/fmtpd_pkg.sv @@
// fmtpd_pkg: shared types, constants and the waypoint table for the tiered position drive
// no dependencies; used by fmtpd_lane and four_motor_tiered_position_drive
`timescale 1ns / 1ps

package fmtpd_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int POINT_COUNT = 10;
  localparam int COUNT_W     = 32;
  localparam int TABLE_ROWS  = 10;
  localparam int ROW_IDX_W   = $clog2(TABLE_ROWS);

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_IDX_W   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_PWM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_PWM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_BST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER    = 3'd7;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_GOTO_POINT = 3'd1,
    KIND_GOTO_COUNT = 3'd2,
    KIND_PATROL     = 3'd3,
    KIND_STOP       = 3'd4,
    KIND_SET_ZERO   = 3'd5,
    KIND_RESET      = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    RS_IDLE     = 2'd0,
    RS_RUNNING  = 2'd1,
    RS_FINISHED = 2'd2,
    RS_ERROR    = 2'd3
  } run_state_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_GOTO   = 2'd1,
    MODE_PATROL = 2'd2
  } run_mode_t;

  typedef struct packed {
    logic [15:0] tolerance;
    logic [15:0] near_thr;
    logic [15:0] mid_thr;
    logic [9:0]  mid_pwm;
    logic [9:0]  fast_pwm;
    logic [7:0]  near_boost;
    logic [9:0]  near_limit;
    logic [9:0]  corner_zone;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tolerance:   16'd15,
    near_thr:    16'd120,
    mid_thr:     16'd500,
    mid_pwm:     10'd300,
    fast_pwm:    10'd360,
    near_boost:  8'd20,
    near_limit:  10'd340,
    corner_zone: 10'd80
  };

  localparam logic [9:0] NEAR_BASE [MOTOR_COUNT] = '{10'd300, 10'd260, 10'd280, 10'd260};

  localparam logic signed [31:0] WAYPOINTS [TABLE_ROWS][MOTOR_COUNT] = '{
    '{ 32'sd4742,  -32'sd2230, -32'sd6082, -32'sd2091},
    '{-32'sd2111,  -32'sd6386, -32'sd1709,  32'sd5640},
    '{-32'sd2343,  -32'sd4616,  32'sd343,   32'sd4434},
    '{ 32'sd3432,  -32'sd498,  -32'sd4507, -32'sd2260},
    '{ 32'sd1884,   32'sd1626, -32'sd3430, -32'sd3441},
    '{-32'sd3290,  -32'sd3593,  32'sd1205,  32'sd2223},
    '{-32'sd4302,  -32'sd2399,  32'sd2836,  32'sd268},
    '{-32'sd6,      32'sd3622, -32'sd2359, -32'sd4471},
    '{-32'sd2004,   32'sd6081, -32'sd1670, -32'sd6413},
    '{-32'sd6316,  -32'sd623,   32'sd4675, -32'sd1865}
  };

  function automatic logic point_ok(input logic [3:0] id);
    point_ok = (id >= 4'd1) && (int'(id) <= POINT_COUNT) && (int'(id) <= TABLE_ROWS);
  endfunction

  // waypoint counts for a point number already known to be valid
  function automatic logic [COUNT_W-1:0] waypoint_count(input logic [3:0] id,
                                                        input int motor);
    logic [3:0] row;
    row = id - 4'd1;
    waypoint_count = WAYPOINTS[row[ROW_IDX_W-1:0]][motor][COUNT_W-1:0];
  endfunction

endpackage

@@ rtl/fmtpd_lane.sv @@
// fmtpd_lane: one motor channel, error to tiered signed pwm with corner boost
// depends on fmtpd_pkg
`timescale 1ns / 1ps

module fmtpd_lane (
  input  logic [1:0]                      lane_idx,
  input  fmtpd_pkg::cfg_t                 cfg,
  input  logic [fmtpd_pkg::COUNT_W-1:0]   target,
  input  logic [fmtpd_pkg::COUNT_W-1:0]   cur,
  input  logic signed [11:0]              pos_x,
  input  logic signed [11:0]              pos_y,
  input  logic                            pos_valid,
  output logic signed [10:0]              pwm
);
  import fmtpd_pkg::*;

  logic [COUNT_W-1:0] err;
  logic               err_neg;
  logic [COUNT_W-1:0] mag;
  logic signed [12:0] xs, ys, zp, zn;
  logic               hit;
  logic [9:0]         base;
  logic [10:0]        boosted;
  logic [9:0]         near_p;
  logic [9:0]         p;

  always_comb begin
    // wraps modulo 2^COUNT_W, read as two's complement
    err     = target - cur;
    err_neg = err[COUNT_W-1];
    mag     = err_neg ? (~err + COUNT_W'(1)) : err;

    xs = {pos_x[11], pos_x};
    ys = {pos_y[11], pos_y};
    zp = $signed({3'b000, cfg.corner_zone});
    zn = -zp;

    unique case (lane_idx)
      2'd0:    hit = (xs <= zn) && (ys >= zp);
      2'd1:    hit = (xs <= zn) && (ys <= zn);
      2'd2:    hit = (xs >= zp) && (ys <= zn);
      default: hit = (xs >= zp) && (ys >= zp);
    endcase

    base    = NEAR_BASE[lane_idx];
    boosted = {1'b0, base} + (hit ? {3'b000, cfg.near_boost} : 11'd0);
    if (!pos_valid) begin
      near_p = base;
    end else if (boosted > {1'b0, cfg.near_limit}) begin
      near_p = cfg.near_limit;
    end else begin
      near_p = boosted[9:0];
    end

    priority if (mag <= COUNT_W'(cfg.tolerance)) begin
      p = 10'd0;
    end else if (mag <= COUNT_W'(cfg.near_thr)) begin
      p = near_p;
    end else if (mag <= COUNT_W'(cfg.mid_thr)) begin
      p = cfg.mid_pwm;
    end else begin
      p = cfg.fast_pwm;
    end

    pwm = err_neg ? -$signed({1'b0, p}) : $signed({1'b0, p});
  end

endmodule

@@ rtl/four_motor_tiered_position_drive.sv @@
// Tiered bang-bang position drive for four cable motors.
// The result of an input transfer is registered in the output register.
// Throughput: one item per cycle unless the input stalls; the four motor lanes and the merge are combinational.
// Input stalls only while a registered result waits and the output side stalls.
// Reset (rst_n, synchronous, active low): state idle, mode none, target point 1,
// zero not set, configuration registers at their default values.
`timescale 1ns / 1ps

module four_motor_tiered_position_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_kind,
  input  logic [3:0]                          in_waypoint_num,
  input  logic signed [31:0]                  in_count_m1,
  input  logic signed [31:0]                  in_count_m2,
  input  logic signed [31:0]                  in_count_m3,
  input  logic signed [31:0]                  in_count_m4,
  input  logic signed [11:0]                  in_pos_x_mm,
  input  logic signed [11:0]                  in_pos_y_mm,
  input  logic                                in_pos_valid,
  input  logic                                in_drive_ok,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [10:0]                  out_pwm_m1,
  output logic signed [10:0]                  out_pwm_m2,
  output logic signed [10:0]                  out_pwm_m3,
  output logic signed [10:0]                  out_pwm_m4,
  output logic                                out_pwm_valid,
  output logic                                out_stop_drive,
  output logic [1:0]                          out_run_state,
  output logic [1:0]                          out_mode_out,
  output logic [3:0]                          out_target_out,
  output logic                                out_accepted,
  output logic                                out_zero_ready,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fmtpd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fmtpd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fmtpd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import fmtpd_pkg::*;

  // configuration registers
  cfg_t                 cfg_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  // control state
  run_state_t           run_state_r, run_state_nxt;
  run_mode_t            run_mode_r, run_mode_nxt;
  logic [3:0]           target_point_r, target_point_nxt;
  logic                 zero_ready_r, zero_ready_nxt;
  logic                 use_custom_r, use_custom_nxt;
  logic [COUNT_W-1:0]   custom_r   [MOTOR_COUNT];
  logic [COUNT_W-1:0]   custom_nxt [MOTOR_COUNT];

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [10:0]   pwm_r [MOTOR_COUNT];
  logic                 pwm_valid_r, stop_r, acc_r;

  logic                 in_fire;
  kind_t                kind;
  logic [COUNT_W-1:0]   in_cnt [MOTOR_COUNT];
  logic [COUNT_W-1:0]   tgt    [MOTOR_COUNT];
  logic signed [10:0]   lane_pwm [MOTOR_COUNT];
  logic                 have_tgt;
  logic                 arrived;
  logic                 pwm_valid_c, stop_c, acc_c;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TOLERANCE: cfg_r.tolerance   <= pwdata[15:0];
        REG_NEAR_THR:  cfg_r.near_thr    <= pwdata[15:0];
        REG_MID_THR:   cfg_r.mid_thr     <= pwdata[15:0];
        REG_MID_PWM:   cfg_r.mid_pwm     <= pwdata[9:0];
        REG_FAST_PWM:  cfg_r.fast_pwm    <= pwdata[9:0];
        REG_NEAR_BST:  cfg_r.near_boost  <= pwdata[7:0];
        REG_NEAR_LIM:  cfg_r.near_limit  <= pwdata[9:0];
        default:       cfg_r.corner_zone <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TOLERANCE: prdata = CFG_DATA_W'(cfg_r.tolerance);
      REG_NEAR_THR:  prdata = CFG_DATA_W'(cfg_r.near_thr);
      REG_MID_THR:   prdata = CFG_DATA_W'(cfg_r.mid_thr);
      REG_MID_PWM:   prdata = CFG_DATA_W'(cfg_r.mid_pwm);
      REG_FAST_PWM:  prdata = CFG_DATA_W'(cfg_r.fast_pwm);
      REG_NEAR_BST:  prdata = CFG_DATA_W'(cfg_r.near_boost);
      REG_NEAR_LIM:  prdata = CFG_DATA_W'(cfg_r.near_limit);
      default:       prdata = CFG_DATA_W'(cfg_r.corner_zone);
    endcase
  end

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign kind     = kind_t'(in_kind);

  assign in_cnt[0] = in_count_m1[COUNT_W-1:0];
  assign in_cnt[1] = in_count_m2[COUNT_W-1:0];
  assign in_cnt[2] = in_count_m3[COUNT_W-1:0];
  assign in_cnt[3] = in_count_m4[COUNT_W-1:0];

  // tick target: custom counts or the current waypoint row
  assign have_tgt = use_custom_r || point_ok(target_point_r);

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
    assign tgt[m] = use_custom_r ? custom_r[m] :
                    (point_ok(target_point_r) ? waypoint_count(target_point_r, m) : '0);

    fmtpd_lane u_lane (
      .lane_idx  (2'(m)),
      .cfg       (cfg_r),
      .target    (tgt[m]),
      .cur       (in_cnt[m]),
      .pos_x     (in_pos_x_mm),
      .pos_y     (in_pos_y_mm),
      .pos_valid (in_pos_valid),
      .pwm       (lane_pwm[m])
    );
  end

  // merge: arrived when every lane is idle
  always_comb begin
    arrived = 1'b1;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      if (lane_pwm[m] != 11'sd0) arrived = 1'b0;
    end
  end

  always_comb begin
    run_state_nxt    = run_state_r;
    run_mode_nxt     = run_mode_r;
    target_point_nxt = target_point_r;
    zero_ready_nxt   = zero_ready_r;
    use_custom_nxt   = use_custom_r;
    custom_nxt       = custom_r;
    pwm_valid_c      = 1'b0;
    stop_c           = 1'b0;
    acc_c            = 1'b0;

    if (in_fire) begin
      unique case (kind)
        KIND_TICK: begin
          if (run_state_r == RS_RUNNING) begin
            if (!have_tgt || !in_drive_ok) begin
              stop_c        = 1'b1;
              run_state_nxt = RS_ERROR;
            end else begin
              pwm_valid_c = 1'b1;
              if (arrived) begin
                stop_c        = 1'b1;
                run_state_nxt = RS_FINISHED;
              end
            end
          end
        end
        KIND_GOTO_POINT, KIND_PATROL: begin
          if (!point_ok(in_waypoint_num) || !zero_ready_r) begin
            run_state_nxt = RS_ERROR;
          end else begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
              custom_nxt[m] = waypoint_count(in_waypoint_num, m);
            end
            target_point_nxt = in_waypoint_num;
            run_mode_nxt     = (kind == KIND_GOTO_POINT) ? MODE_GOTO : MODE_PATROL;
            use_custom_nxt   = 1'b0;
            run_state_nxt    = RS_RUNNING;
            acc_c            = 1'b1;
            stop_c           = 1'b1;
          end
        end
        KIND_GOTO_COUNT: begin
          if (!zero_ready_r) begin
            run_state_nxt = RS_ERROR;
          end else begin
            custom_nxt     = in_cnt;
            run_mode_nxt   = MODE_GOTO;
            use_custom_nxt = 1'b1;
            run_state_nxt  = RS_RUNNING;
            stop_c         = 1'b1;
            acc_c          = 1'b1;
          end
        end
        KIND_STOP: begin
          stop_c         = 1'b1;
          run_state_nxt  = RS_IDLE;
          run_mode_nxt   = MODE_NONE;
          use_custom_nxt = 1'b0;
        end
        KIND_SET_ZERO: begin
          if (in_drive_ok) begin
            zero_ready_nxt = 1'b1;
            run_state_nxt  = RS_IDLE;
            acc_c          = 1'b1;
          end else begin
            zero_ready_nxt = 1'b0;
            run_state_nxt  = RS_ERROR;
          end
        end
        KIND_RESET: begin
          run_state_nxt    = RS_IDLE;
          run_mode_nxt     = MODE_NONE;
          target_point_nxt = 4'd1;
        end
        default: ;  // unused code only reports the state
      endcase
    end

    out_valid_nxt = in_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_state_r    <= RS_IDLE;
      run_mode_r     <= MODE_NONE;
      target_point_r <= 4'd1;
      zero_ready_r   <= 1'b0;
      use_custom_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      run_state_r    <= run_state_nxt;
      run_mode_r     <= run_mode_nxt;
      target_point_r <= target_point_nxt;
      zero_ready_r   <= zero_ready_nxt;
      use_custom_r   <= use_custom_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // custom targets are only read after a goto-counts transfer has written them
  always_ff @(posedge clk) begin
    custom_r <= custom_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        pwm_r[m] <= pwm_valid_c ? lane_pwm[m] : 11'sd0;
      end
      pwm_valid_r <= pwm_valid_c;
      stop_r      <= stop_c;
      acc_r       <= acc_c;
    end
  end

  // state fields show the state right after the item, which the state registers still hold
  assign out_valid      = out_valid_r;
  assign out_pwm_m1     = pwm_r[0];
  assign out_pwm_m2     = pwm_r[1];
  assign out_pwm_m3     = pwm_r[2];
  assign out_pwm_m4     = pwm_r[3];
  assign out_pwm_valid  = pwm_valid_r;
  assign out_stop_drive = stop_r;
  assign out_run_state  = run_state_r;
  assign out_mode_out   = run_mode_r;
  assign out_target_out = target_point_r;
  assign out_accepted   = acc_r;
  assign out_zero_ready = zero_ready_r;

endmodule

@@ tb/four_motor_tiered_position_drive_tb.sv @@
// four_motor_tiered_position_drive_tb: self-checking bench with a scoreboard class that
// predicts every drive result and compares it field by field; register setup over the apb port
// depends on fmtpd_pkg and four_motor_tiered_position_drive
`timescale 1ns / 1ps

module four_motor_tiered_position_drive_tb;
  import fmtpd_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         waypoint_num;
    logic [3:0][31:0]   count;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic               pos_valid;
    logic               drive_ok;
  } drive_cmd_t;

  typedef struct packed {
    logic [3:0][10:0] pwm;
    logic             pwm_valid;
    logic             stop_drive;
    logic [1:0]       run_state;
    logic [1:0]       mode;
    logic [3:0]       target;
    logic             accepted;
    logic             zero_ready;
  } drive_result_t;

  class drive_scoreboard;
    cfg_t             regs;
    run_state_t       state;
    run_mode_t        mode;
    logic [3:0]       point;
    bit               zero_set;
    bit               custom_on;
    logic [3:0][31:0] custom_goal;
    drive_result_t    expected_drive[$];
    int               fails;

    function new();
      regs = CFG_RESET;
      state = RS_IDLE;
      mode = MODE_NONE;
      point = 4'd1;
      zero_set = 0;
      custom_on = 0;
      custom_goal = '0;
      fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_TOLERANCE: regs.tolerance   = v[15:0];
        REG_NEAR_THR:  regs.near_thr    = v[15:0];
        REG_MID_THR:   regs.mid_thr     = v[15:0];
        REG_MID_PWM:   regs.mid_pwm     = v[9:0];
        REG_FAST_PWM:  regs.fast_pwm    = v[9:0];
        REG_NEAR_BST:  regs.near_boost  = v[7:0];
        REG_NEAR_LIM:  regs.near_limit  = v[9:0];
        REG_CORNER:    regs.corner_zone = v[9:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] goal(int m);
      if (custom_on) return custom_goal[m];
      return WAYPOINTS[int'(point) - 1][m];
    endfunction

    // signed drive for one motor from its wrapped error
    function int tier_pwm(int m, logic [31:0] err_bits, int x, int y, bit pv);
      logic signed [31:0] err;
      longint mag;
      int p;
      int z;
      bit hit;
      err = err_bits;
      mag = (err < 0) ? -longint'(err) : longint'(err);
      if (mag <= longint'(regs.tolerance)) return 0;
      if (mag <= longint'(regs.near_thr)) begin
        p = int'(NEAR_BASE[m]);
        if (pv) begin
          z = int'(regs.corner_zone);
          case (m)
            0: hit = (x <= -z) && (y >= z);
            1: hit = (x <= -z) && (y <= -z);
            2: hit = (x >= z) && (y <= -z);
            default: hit = (x >= z) && (y >= z);
          endcase
          if (hit) p += int'(regs.near_boost);
          if (p > int'(regs.near_limit)) p = int'(regs.near_limit);
        end
      end else if (mag <= longint'(regs.mid_thr)) begin
        p = int'(regs.mid_pwm);
      end else begin
        p = int'(regs.fast_pwm);
      end
      return (err > 0) ? p : -p;
    endfunction

    function void note_command(drive_cmd_t c);
      drive_result_t r;
      int p;
      bit arrived;
      r = '0;
      case (c.kind)
        KIND_TICK: begin
          if (state == RS_RUNNING) begin
            if (!c.drive_ok) begin
              r.stop_drive = 1;
              state = RS_ERROR;
            end else begin
              arrived = 1;
              for (int m = 0; m < MOTOR_COUNT; m++) begin
                p = tier_pwm(m, goal(m) - c.count[m], int'(c.pos_x), int'(c.pos_y),
                             c.pos_valid);
                r.pwm[m] = p[10:0];
                if (p != 0) arrived = 0;
              end
              r.pwm_valid = 1;
              if (arrived) begin
                r.stop_drive = 1;
                state = RS_FINISHED;
              end
            end
          end
        end
        KIND_GOTO_POINT, KIND_PATROL: begin
          if (c.waypoint_num >= 4'd1 && int'(c.waypoint_num) <= POINT_COUNT &&
              int'(c.waypoint_num) <= TABLE_ROWS && zero_set) begin
            for (int m = 0; m < MOTOR_COUNT; m++)
              custom_goal[m] = WAYPOINTS[int'(c.waypoint_num) - 1][m];
            point = c.waypoint_num;
            if (c.kind == KIND_GOTO_POINT) mode = MODE_GOTO;
            else mode = MODE_PATROL;
            custom_on = 0;
            state = RS_RUNNING;
            r.accepted = 1;
            r.stop_drive = 1;
          end else begin
            state = RS_ERROR;
          end
        end
        KIND_GOTO_COUNT: begin
          if (!zero_set) begin
            state = RS_ERROR;
          end else begin
            custom_goal = c.count;
            mode = MODE_GOTO;
            custom_on = 1;
            state = RS_RUNNING;
            r.accepted = 1;
            r.stop_drive = 1;
          end
        end
        KIND_STOP: begin
          r.stop_drive = 1;
          state = RS_IDLE;
          mode = MODE_NONE;
          custom_on = 0;
        end
        KIND_SET_ZERO: begin
          if (c.drive_ok) begin
            zero_set = 1;
            state = RS_IDLE;
            r.accepted = 1;
          end else begin
            zero_set = 0;
            state = RS_ERROR;
          end
        end
        KIND_RESET: begin
          state = RS_IDLE;
          mode = MODE_NONE;
          point = 4'd1;
        end
        default: ;
      endcase
      r.run_state = state;
      r.mode = mode;
      r.target = point;
      r.zero_ready = zero_set;
      expected_drive.push_back(r);
    endfunction

    function void field(string name, int e, int a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        fails++;
      end
    endfunction

    function void check_drive(drive_result_t got);
      drive_result_t e;
      if (expected_drive.size() == 0) begin
        $error("drive result with no transfer pending");
        fails++;
        return;
      end
      e = expected_drive.pop_front();
      for (int m = 0; m < MOTOR_COUNT; m++)
        field($sformatf("pwm_m%0d", m + 1), $signed(e.pwm[m]), $signed(got.pwm[m]));
      field("pwm_valid", e.pwm_valid, got.pwm_valid);
      field("stop_drive", e.stop_drive, got.stop_drive);
      field("run_state", e.run_state, got.run_state);
      field("mode_out", e.mode, got.mode);
      field("target_out", e.target, got.target);
      field("accepted", e.accepted, got.accepted);
      field("zero_ready", e.zero_ready, got.zero_ready);
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_kind = '0;
  logic [3:0]            in_waypoint_num = '0;
  logic signed [31:0]    in_count_m1 = '0;
  logic signed [31:0]    in_count_m2 = '0;
  logic signed [31:0]    in_count_m3 = '0;
  logic signed [31:0]    in_count_m4 = '0;
  logic signed [11:0]    in_pos_x_mm = '0;
  logic signed [11:0]    in_pos_y_mm = '0;
  logic                  in_pos_valid = 1'b0;
  logic                  in_drive_ok = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [10:0]    out_pwm_m1, out_pwm_m2, out_pwm_m3, out_pwm_m4;
  logic                  out_pwm_valid, out_stop_drive;
  logic [1:0]            out_run_state, out_mode_out;
  logic [3:0]            out_target_out;
  logic                  out_accepted, out_zero_ready;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  drive_scoreboard sb;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  stall_left = 0;
  bit  quiet = 0;
  int  sent_items = 0;

  four_motor_tiered_position_drive dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("four_motor_tiered_position_drive: mismatch");
    $finish;
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    drive_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.pwm[0] = out_pwm_m1;
      got.pwm[1] = out_pwm_m2;
      got.pwm[2] = out_pwm_m3;
      got.pwm[3] = out_pwm_m4;
      got.pwm_valid = out_pwm_valid;
      got.stop_drive = out_stop_drive;
      got.run_state = out_run_state;
      got.mode = out_mode_out;
      got.target = out_target_out;
      got.accepted = out_accepted;
      got.zero_ready = out_zero_ready;
      sb.check_drive(got);
    end
  end

  function automatic drive_cmd_t plain_cmd(logic [2:0] kind, logic [3:0] pid, logic ok);
    drive_cmd_t c;
    c = '0;
    c.kind = kind;
    c.waypoint_num = pid;
    c.pos_valid = 1'b1;
    c.drive_ok = ok;
    return c;
  endfunction

  // tick whose errors (goal minus count) equal d
  function automatic drive_cmd_t tick_cmd(input int d [4], input int x, input int y,
                                          input logic pv, input logic ok);
    drive_cmd_t c;
    c = plain_cmd(KIND_TICK, 4'd0, ok);
    for (int m = 0; m < MOTOR_COUNT; m++) c.count[m] = sb.goal(m) - 32'(d[m]);
    c.pos_x = x[11:0];
    c.pos_y = y[11:0];
    c.pos_valid = pv;
    return c;
  endfunction

  function automatic drive_cmd_t noise_cmd();
    drive_cmd_t c;
    c.kind = 3'($urandom_range(0, 7));
    c.waypoint_num = 4'($urandom_range(0, 15));
    for (int m = 0; m < MOTOR_COUNT; m++) c.count[m] = $urandom;
    c.pos_x = 12'($urandom_range(0, 4095));
    c.pos_y = 12'($urandom_range(0, 4095));
    c.pos_valid = 1'($urandom_range(0, 1));
    c.drive_ok = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic int arrive_delta();
    int tol;
    tol = int'(sb.regs.tolerance);
    return int'($urandom_range(0, 2 * tol)) - tol;
  endfunction

  // errors clustered on the tier edges
  function automatic int tier_delta();
    int d;
    case ($urandom_range(0, 9))
      0: d = 0;
      1: d = int'(sb.regs.tolerance);
      2: d = int'(sb.regs.tolerance) + 1;
      3: d = int'(sb.regs.near_thr);
      4: d = int'(sb.regs.near_thr) + 1;
      5: d = int'(sb.regs.mid_thr);
      6: d = int'(sb.regs.mid_thr) + 1;
      7: d = int'($urandom_range(0, 1400)) - 700;
      default: d = int'($urandom);
    endcase
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  function automatic int pick_coord();
    int z;
    z = int'(sb.regs.corner_zone);
    case ($urandom_range(0, 5))
      0: return z;
      1: return -z;
      2: return z - 1;
      3: return 1 - z;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  task automatic push_cmd(drive_cmd_t c);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= c.kind;
    in_waypoint_num <= c.waypoint_num;
    in_count_m1 <= c.count[0];
    in_count_m2 <= c.count[1];
    in_count_m3 <= c.count[2];
    in_count_m4 <= c.count[3];
    in_pos_x_mm <= c.pos_x;
    in_pos_y_mm <= c.pos_y;
    in_pos_valid <= c.pos_valid;
    in_drive_ok <= c.drive_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    sb.note_command(c);
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic configure(int ph);
    int tol, nthr, mthr, mpwm, fpwm, bst, lim, zone;
    if (ph == 1) begin
      {tol, nthr, mthr, mpwm, fpwm, bst, lim, zone} = '0;
    end else if (ph == 2) begin
      tol = 65535; nthr = 65535; mthr = 65535;
      mpwm = 1023; fpwm = 1023; bst = 255; lim = 1023; zone = 1000;
    end else if ($urandom_range(0, 1)) begin
      tol = $urandom_range(0, 200);
      nthr = tol + $urandom_range(0, 600);
      mthr = nthr + $urandom_range(0, 2000);
      mpwm = $urandom_range(0, 1023); fpwm = $urandom_range(0, 1023);
      bst = $urandom_range(0, 255); lim = $urandom_range(0, 1023);
      zone = $urandom_range(0, 1000);
    end else begin
      tol = $urandom_range(0, 65535); nthr = $urandom_range(0, 65535);
      mthr = $urandom_range(0, 65535);
      mpwm = $urandom_range(0, 1023); fpwm = $urandom_range(0, 1023);
      bst = $urandom_range(0, 255); lim = $urandom_range(0, 1023);
      zone = $urandom_range(0, 1000);
    end
    apb_write(REG_TOLERANCE, tol);
    apb_write(REG_NEAR_THR, nthr);
    apb_write(REG_MID_THR, mthr);
    apb_write(REG_MID_PWM, mpwm);
    apb_write(REG_FAST_PWM, fpwm);
    apb_write(REG_NEAR_BST, bst);
    apb_write(REG_NEAR_LIM, lim);
    apb_write(REG_CORNER, zone);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // start a move and walk it toward arrival, with occasional junk in between
  task automatic random_move();
    drive_cmd_t c;
    int d [4];
    int n;
    if (!sb.zero_set) push_cmd(plain_cmd(KIND_SET_ZERO, 4'($urandom_range(0, 15)), 1'b1));
    case ($urandom_range(0, 2))
      0: c = plain_cmd(KIND_GOTO_POINT, 4'($urandom_range(1, 10)), 1'b1);
      1: c = plain_cmd(KIND_PATROL, 4'($urandom_range(1, 10)), 1'b1);
      default: begin
        c = plain_cmd(KIND_GOTO_COUNT, 4'($urandom_range(0, 15)), 1'b1);
        for (int m = 0; m < MOTOR_COUNT; m++)
          c.count[m] = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : 32'($urandom_range(0, 16000)) - 32'd8000;
      end
    endcase
    push_cmd(c);
    n = $urandom_range(1, 8);
    for (int j = 0; j <= n; j++) begin
      if ($urandom_range(0, 9) == 0) push_cmd(noise_cmd());
      for (int m = 0; m < MOTOR_COUNT; m++)
        d[m] = (j == n || $urandom_range(0, n) < j) ? arrive_delta() : tier_delta();
      push_cmd(tick_cmd(d, pick_coord(), pick_coord(), $urandom_range(0, 9) != 0,
                        $urandom_range(0, 29) != 0));
    end
  endtask

  initial begin
    drive_cmd_t c;
    int goal_items;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    stall_pct = 20;
    push_cmd(plain_cmd(KIND_TICK, 4'd0, 1'b1));
    // starts before the zero is set
    push_cmd(plain_cmd(KIND_GOTO_POINT, 4'd3, 1'b1));
    push_cmd(plain_cmd(KIND_GOTO_COUNT, 4'd0, 1'b1));
    push_cmd(plain_cmd(KIND_PATROL, 4'd5, 1'b1));
    push_cmd(plain_cmd(KIND_SET_ZERO, 4'd0, 1'b0));
    push_cmd(plain_cmd(KIND_SET_ZERO, 4'd0, 1'b1));
    // invalid waypoint numbers
    push_cmd(plain_cmd(KIND_GOTO_POINT, 4'd0, 1'b1));
    push_cmd(plain_cmd(KIND_PATROL, 4'd11, 1'b1));
    push_cmd(plain_cmd(KIND_GOTO_POINT, 4'd15, 1'b1));
    push_cmd(plain_cmd(KIND_GOTO_POINT, 4'd1, 1'b1));
    push_cmd(tick_cmd('{50, 50, 50, 50}, 0, 0, 1'b1, 1'b0));
    push_cmd(plain_cmd(KIND_PATROL, 4'd10, 1'b1));
    // every tier, motor 1 boosted in its corner
    push_cmd(tick_cmd('{50, -300, 10000, 15}, -80, 80, 1'b1, 1'b1));
    push_cmd(tick_cmd('{-16, 120, -121, -500}, 80, 80, 1'b0, 1'b1));
    push_cmd(tick_cmd('{-100, -100, 100, 100}, -80, -80, 1'b1, 1'b1));
    push_cmd(tick_cmd('{501, -501, 100, 100}, 80, -79, 1'b1, 1'b1));
    // count wraparound at the 32-bit extremes
    c = plain_cmd(KIND_GOTO_COUNT, 4'd0, 1'b1);
    c.count = {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    push_cmd(c);
    c = plain_cmd(KIND_TICK, 4'd0, 1'b1);
    c.count = {32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    c.pos_x = 12'sh7FF;
    c.pos_y = 12'sh800;
    push_cmd(c);
    push_cmd(tick_cmd('{0, 15, -15, 3}, 0, 0, 1'b1, 1'b1));
    push_cmd(tick_cmd('{400, 400, 400, 400}, 0, 0, 1'b1, 1'b1));
    push_cmd(plain_cmd(KIND_UNUSED, 4'd7, 1'b1));
    push_cmd(plain_cmd(KIND_GOTO_POINT, 4'd2, 1'b1));
    push_cmd(plain_cmd(KIND_STOP, 4'd0, 1'b1));
    push_cmd(plain_cmd(KIND_GOTO_POINT, 4'd4, 1'b1));
    push_cmd(plain_cmd(KIND_RESET, 4'd0, 1'b1));
    push_cmd(plain_cmd(KIND_TICK, 4'd0, 1'b1));

    sent_items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph != 0) configure(ph);
      quiet = (ph == 7);
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 50;
      endcase
      stall_pct = 5 * $urandom_range(0, 8);
      goal_items = sent_items + 156;
      while (sent_items < goal_items) begin
        if ($urandom_range(0, 5) == 0) push_cmd(noise_cmd());
        else random_move();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("four_motor_tiered_position_drive: match");
    end else begin
      $display("four_motor_tiered_position_drive: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fmtpd_pkg.sv
rtl/fmtpd_lane.sv
rtl/four_motor_tiered_position_drive.sv
tb/four_motor_tiered_position_drive_tb.sv
